/* hdl/vector_sum_to_polar_assert.svh */
// Assertion helpers for the vector_sum_to_polar design.
`ifndef VECTOR_SUM_TO_POLAR_ASSERT_SVH
`define VECTOR_SUM_TO_POLAR_ASSERT_SVH

// Same-cycle implication, quiet while reset is held.
`define VSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vsp: same-cycle check failed");

// Next-cycle implication, quiet while reset is held.
`define VSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vsp: next-cycle check failed");

`endif

/* hdl/vsp_pkg.sv */
package vsp_pkg;

    localparam int COMPONENT_WIDTH_DEF   = 16;
    localparam int CORDIC_ITERATIONS_DEF = 16;

    // Fraction bits added to the CORDIC x/y datapath.
    localparam int FRAC_SHIFT   = 16;
    // Headroom for CORDIC gain plus the sign bit.
    localparam int GROWTH_BITS  = 3;
    // Cap on the sum-of-squares width; the sum wraps at the capped width.
    localparam int SUM_SQ_CAP   = 64;

    localparam int ANGLE_ACC_W       = 25;
    localparam int ANGLE_ROUND_SHIFT = 9;
    localparam int MAG_W             = 17;
    localparam int ANGLE_W           = 17;
    localparam int QUARTER_DEG       = 11520;
    localparam int HALF_DEG          = 23040;

    typedef logic signed [ANGLE_ACC_W-1:0] t_angle_acc;

    typedef struct packed {
        logic sx_zero;
        logic sx_neg;
        logic sy_zero;
        logic sy_pos;
    } t_flags;

    // atan(2^-idx) in units of 2^-16 degree, rounded to nearest.
    function automatic t_angle_acc atan_entry(input int idx);
        int val;
        case (idx)
            0:  val = 2949120;
            1:  val = 1740967;
            2:  val = 919879;
            3:  val = 466945;
            4:  val = 234379;
            5:  val = 117304;
            6:  val = 58666;
            7:  val = 29335;
            8:  val = 14668;
            9:  val = 7334;
            10: val = 3667;
            11: val = 1833;
            12: val = 917;
            13: val = 458;
            14: val = 229;
            15: val = 115;
            16: val = 57;
            17: val = 29;
            18: val = 14;
            19: val = 7;
            20: val = 4;
            21: val = 2;
            22: val = 1;
            default: val = 0;
        endcase
        return t_angle_acc'(val);
    endfunction

endpackage

/* hdl/vsp_if.sv */
interface vsp_in_if import vsp_pkg::*; #(
    parameter int W = COMPONENT_WIDTH_DEF
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] first_x;
    logic signed [W-1:0] first_y;
    logic signed [W-1:0] second_x;
    logic signed [W-1:0] second_y;

    modport source (output valid, output first_x, output first_y,
                    output second_x, output second_y, input ready);
    modport sink   (input valid, input first_x, input first_y,
                    input second_x, input second_y, output ready);
endinterface

interface vsp_out_if import vsp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [MAG_W-1:0]          sum_magnitude;
    logic signed [ANGLE_W-1:0] sum_angle;
    logic                      zero_vector;

    modport source (output valid, output sum_magnitude, output sum_angle,
                    output zero_vector, input ready);
    modport sink   (input valid, input sum_magnitude, input sum_angle,
                    input zero_vector, output ready);
endinterface

/* hdl/vsp_front.sv */
module vsp_front import vsp_pkg::*; #(
    parameter int W  = COMPONENT_WIDTH_DEF,
    parameter int SW = 2 * COMPONENT_WIDTH_DEF + 2,
    parameter int CW = COMPONENT_WIDTH_DEF + FRAC_SHIFT + GROWTH_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [W-1:0]  i_first_x,
    input  logic signed [W-1:0]  i_first_y,
    input  logic signed [W-1:0]  i_second_x,
    input  logic signed [W-1:0]  i_second_y,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [SW-1:0]        o_s,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output t_flags               o_flags
);

    localparam int UW = W + 1;

    logic                 r_v1, r_v2, r_v3;
    logic                 w_ld1, w_ld2, w_ld3;

    logic signed [UW-1:0] r_sx, r_sy, n_sx, n_sy;

    logic [UW-1:0]        w_ux, w_uy;
    logic [2*UW-1:0]      w_px, w_py;
    logic [SW-1:0]        r_sqx, r_sqy, n_sqx, n_sqy;
    logic signed [CW-1:0] r_x2, r_y2, n_x2, n_y2;
    t_flags               r_f2, n_f2;

    logic [SW-1:0]        r_s, n_s;
    logic signed [CW-1:0] r_x3, r_y3;
    t_flags               r_f3;

    assign w_ld3   = !r_v3 || i_ready;
    assign w_ld2   = !r_v2 || w_ld3;
    assign w_ld1   = !r_v1 || w_ld2;
    assign o_ready = w_ld1;

    // stage 1: exact vector sum
    always_comb begin
        n_sx = $signed({i_first_x[W-1], i_first_x}) + $signed({i_second_x[W-1], i_second_x});
        n_sy = $signed({i_first_y[W-1], i_first_y}) + $signed({i_second_y[W-1], i_second_y});
    end

    // stage 2: squares, CORDIC start values, case flags
    always_comb begin
        w_ux  = r_sx[UW-1] ? UW'(-r_sx) : UW'(r_sx);
        w_uy  = r_sy[UW-1] ? UW'(-r_sy) : UW'(r_sy);
        w_px  = w_ux * w_ux;
        w_py  = w_uy * w_uy;
        n_sqx = w_px[SW-1:0];
        n_sqy = w_py[SW-1:0];
        n_x2  = CW'($signed({1'b0, w_ux, {FRAC_SHIFT{1'b0}}}));
        n_y2  = CW'($signed({r_sy, {FRAC_SHIFT{1'b0}}}));
        n_f2.sx_zero = (r_sx == '0);
        n_f2.sx_neg  = r_sx[UW-1];
        n_f2.sy_zero = (r_sy == '0);
        n_f2.sy_pos  = !r_sy[UW-1] && (r_sy != '0);
    end

    // stage 3: sum of squares, wrapping at SW bits
    assign n_s = r_sqx + r_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_ld1) r_v1 <= i_valid;
            if (w_ld2) r_v2 <= r_v1;
            if (w_ld3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
        end
        if (w_ld2) begin
            r_sqx <= n_sqx;
            r_sqy <= n_sqy;
            r_x2  <= n_x2;
            r_y2  <= n_y2;
            r_f2  <= n_f2;
        end
        if (w_ld3) begin
            r_s  <= n_s;
            r_x3 <= r_x2;
            r_y3 <= r_y2;
            r_f3 <= r_f2;
        end
    end

    assign o_valid = r_v3;
    assign o_s     = r_s;
    assign o_x     = r_x3;
    assign o_y     = r_y3;
    assign o_flags = r_f3;

endmodule

/* hdl/vsp_stage.sv */
module vsp_stage import vsp_pkg::*; #(
    parameter int SW    = 2 * COMPONENT_WIDTH_DEF + 2,
    parameter int NS    = COMPONENT_WIDTH_DEF + 1,
    parameter int CW    = COMPONENT_WIDTH_DEF + FRAC_SHIFT + GROWTH_BITS,
    parameter int STAGE = 0,
    parameter int ITERS = CORDIC_ITERATIONS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [SW-1:0]        i_s,
    input  logic [NS+1:0]        i_rem,
    input  logic [NS-1:0]        i_root,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  t_angle_acc           i_z,
    input  t_flags               i_flags,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [SW-1:0]        o_s,
    output logic [NS+1:0]        o_rem,
    output logic [NS-1:0]        o_root,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output t_angle_acc           o_z,
    output t_flags               o_flags
);

    logic                 r_valid;
    logic                 w_ld;
    logic [NS+1:0]        n_rem, r_rem;
    logic [NS-1:0]        n_root, r_root;
    logic signed [CW-1:0] n_x, n_y, r_x, r_y;
    t_angle_acc           n_z, r_z;
    logic [SW-1:0]        r_s;
    t_flags               r_flags;

    assign w_ld    = !r_valid || i_ready;
    assign o_ready = w_ld;

    // one result bit of the square root: bring down two bits, try root*4+1
    if (STAGE < NS) begin : g_sqrt
        logic [NS+1:0] w_cur, w_trial;
        always_comb begin
            w_cur   = {i_rem[NS-1:0], i_s[SW-1-2*STAGE -: 2]};
            w_trial = {i_root, 2'b01};
            if (w_cur >= w_trial) begin
                n_rem  = w_cur - w_trial;
                n_root = {i_root[NS-2:0], 1'b1};
            end else begin
                n_rem  = w_cur;
                n_root = {i_root[NS-2:0], 1'b0};
            end
        end
    end else begin : g_sqrt_hold
        assign n_rem  = i_rem;
        assign n_root = i_root;
    end

    // one CORDIC vectoring rotation: drive y toward zero
    if (STAGE < ITERS) begin : g_cordic
        logic signed [CW-1:0] w_xs, w_ys;
        always_comb begin
            w_xs = i_x >>> STAGE;
            w_ys = i_y >>> STAGE;
            if (!i_y[CW-1]) begin
                n_x = i_x + w_ys;
                n_y = i_y - w_xs;
                n_z = i_z + atan_entry(STAGE);
            end else begin
                n_x = i_x - w_ys;
                n_y = i_y + w_xs;
                n_z = i_z - atan_entry(STAGE);
            end
        end
    end else begin : g_cordic_hold
        assign n_x = i_x;
        assign n_y = i_y;
        assign n_z = i_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_s     <= i_s;
            r_rem   <= n_rem;
            r_root  <= n_root;
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_s     = r_s;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_flags = r_flags;

endmodule

/* hdl/vsp_back.sv */
`include "vector_sum_to_polar_assert.svh"

module vsp_back import vsp_pkg::*; #(
    parameter int NS = COMPONENT_WIDTH_DEF + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [NS+1:0]             i_rem,
    input  logic [NS-1:0]             i_root,
    input  t_angle_acc                i_z,
    input  t_flags                    i_flags,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [MAG_W-1:0]          o_sum_magnitude,
    output logic signed [ANGLE_W-1:0] o_sum_angle,
    output logic                      o_zero_vector
);

    localparam int ROUND_BIAS = 1 << (ANGLE_ROUND_SHIFT - 1);

    logic                      r_valid;
    logic                      w_ld;
    logic                      w_round;
    logic [NS:0]               w_mag;
    t_angle_acc                w_zsum, w_a;
    logic signed [ANGLE_W-1:0] w_clamped;
    logic [MAG_W-1:0]          n_mag, r_mag;
    logic signed [ANGLE_W-1:0] n_ang, r_ang;
    logic                      n_zero, r_zero;

    assign w_ld    = !r_valid || i_ready;
    assign o_ready = w_ld;

    always_comb begin
        // remainder above root means the true root lies past root + 1/2
        w_round = i_rem > {2'b00, i_root};
        w_mag   = {1'b0, i_root} + (NS+1)'(w_round);
        n_mag   = MAG_W'(w_mag);

        w_zsum = i_z + t_angle_acc'(ROUND_BIAS);
        w_a    = w_zsum >>> ANGLE_ROUND_SHIFT;
        if (w_a > QUARTER_DEG) begin
            w_clamped = ANGLE_W'(QUARTER_DEG);
        end else if (w_a < -QUARTER_DEG) begin
            w_clamped = ANGLE_W'(-QUARTER_DEG);
        end else begin
            w_clamped = ANGLE_W'(w_a);
        end

        n_zero = i_flags.sx_zero && i_flags.sy_zero;
        if (n_zero) begin
            n_ang = '0;
        end else if (i_flags.sx_zero) begin
            n_ang = i_flags.sy_pos ? ANGLE_W'(QUARTER_DEG) : ANGLE_W'(-QUARTER_DEG);
        end else if (!i_flags.sx_neg) begin
            n_ang = w_clamped;
        end else begin
            // left half plane: mirror around 90 degrees
            n_ang = ANGLE_W'(HALF_DEG) - w_clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_mag  <= n_mag;
            r_ang  <= n_ang;
            r_zero <= n_zero;
        end
    end

    assign o_valid         = r_valid;
    assign o_sum_magnitude = r_mag;
    assign o_sum_angle     = r_ang;
    assign o_zero_vector   = r_zero;

    `VSP_ASSERT_NOW(a_zero_clean, i_clk, i_rst_n, r_valid && r_zero, r_mag == '0 && r_ang == '0)
    `VSP_ASSERT_NOW(a_angle_span, i_clk, i_rst_n, r_valid, r_ang >= -QUARTER_DEG && r_ang <= QUARTER_DEG + HALF_DEG)
    `VSP_ASSERT_NEXT(a_right_half, i_clk, i_rst_n, i_valid && w_ld && !i_flags.sx_neg && !i_flags.sx_zero, r_ang >= -QUARTER_DEG && r_ang <= QUARTER_DEG)

endmodule

/* hdl/vector_sum_to_polar.sv */
// Channel   Direction  Handshake      Payload
// i_vec     in         valid / ready  first_x, first_y, second_x, second_y
// o_pol     out        valid / ready  sum_magnitude, sum_angle, zero_vector
//
// One item per cycle sustained while the output is not stalled. Pipeline stages, with
// DEPTH = max(CORDIC_ITERATIONS, SW/2): three front stages (sum, squares, sum of
// squares), one stage per square-root bit / CORDIC rotation, one output stage.
// With the defaults, DEPTH is set by the 17 square-root bit stages.
// Reset is synchronous and clears only the valid bits.
// Each stage holds while the next one is full and stalled; empty stages fill in.

module vector_sum_to_polar import vsp_pkg::*; #(
    parameter int COMPONENT_WIDTH   = COMPONENT_WIDTH_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vsp_in_if.sink     i_vec,
    vsp_out_if.source  o_pol
);

    localparam int SW    = (2 * COMPONENT_WIDTH + 2 > SUM_SQ_CAP) ? SUM_SQ_CAP
                                                                  : 2 * COMPONENT_WIDTH + 2;
    localparam int NS    = SW / 2;
    localparam int CW    = COMPONENT_WIDTH + FRAC_SHIFT + GROWTH_BITS;
    localparam int DEPTH = (NS > CORDIC_ITERATIONS) ? NS : CORDIC_ITERATIONS;

    logic                 w_valid [0:DEPTH];
    logic                 w_ready [0:DEPTH];
    logic [SW-1:0]        w_s     [0:DEPTH];
    logic [NS+1:0]        w_rem   [0:DEPTH];
    logic [NS-1:0]        w_root  [0:DEPTH];
    logic signed [CW-1:0] w_x     [0:DEPTH];
    logic signed [CW-1:0] w_y     [0:DEPTH];
    t_angle_acc           w_z     [0:DEPTH];
    t_flags               w_flags [0:DEPTH];

    vsp_front #(
        .W  (COMPONENT_WIDTH),
        .SW (SW),
        .CW (CW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_vec.valid),
        .o_ready    (i_vec.ready),
        .i_first_x  (i_vec.first_x),
        .i_first_y  (i_vec.first_y),
        .i_second_x (i_vec.second_x),
        .i_second_y (i_vec.second_y),
        .o_valid    (w_valid[0]),
        .i_ready    (w_ready[0]),
        .o_s        (w_s[0]),
        .o_x        (w_x[0]),
        .o_y        (w_y[0]),
        .o_flags    (w_flags[0])
    );

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_z[0]    = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_stage
        vsp_stage #(
            .SW    (SW),
            .NS    (NS),
            .CW    (CW),
            .STAGE (g),
            .ITERS (CORDIC_ITERATIONS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_s     (w_s[g]),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_flags (w_flags[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_s     (w_s[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_flags (w_flags[g+1])
        );
    end

    vsp_back #(
        .NS (NS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_valid[DEPTH]),
        .o_ready         (w_ready[DEPTH]),
        .i_rem           (w_rem[DEPTH]),
        .i_root          (w_root[DEPTH]),
        .i_z             (w_z[DEPTH]),
        .i_flags         (w_flags[DEPTH]),
        .o_valid         (o_pol.valid),
        .i_ready         (o_pol.ready),
        .o_sum_magnitude (o_pol.sum_magnitude),
        .o_sum_angle     (o_pol.sum_angle),
        .o_zero_vector   (o_pol.zero_vector)
    );

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb import vsp_pkg::*; ();

    localparam int CW          = 16;
    localparam int ROTATIONS   = 16;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int ITEMS_PER_PHASE = 375;

    typedef struct {
        logic [MAG_W-1:0]          mag;
        logic signed [ANGLE_W-1:0] ang;
        logic                      zero;
    } t_polar;

    // atan(2^-i) in 2^-16 degree
    localparam longint ATAN_STEP [32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    class polar_scoreboard;
        t_polar pending[$];
        int     mismatches;
        int     checked;

        function t_polar polar_of_sum(logic signed [CW-1:0] fx, logic signed [CW-1:0] fy,
                                      logic signed [CW-1:0] gx, logic signed [CW-1:0] gy);
            longint          sx, sy, ux, uy, xr, yr, zr, xs, ys, a, ang;
            longint unsigned ssq, rem, root, bitv;
            t_polar          res;
            sx = longint'(fx) + longint'(gx);
            sy = longint'(fy) + longint'(gy);
            ux = (sx < 0) ? -sx : sx;
            uy = (sy < 0) ? -sy : sy;

            // digit-by-digit square root, then round to nearest
            ssq  = ux * ux + uy * uy;
            rem  = ssq;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rem)
                bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem  = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            if (ssq - root * root > root)
                root = root + 1;

            res.zero = 1'b0;
            if (sx == 0 && sy == 0) begin
                ang      = 0;
                res.zero = 1'b1;
            end else if (sx == 0) begin
                ang = (sy > 0) ? QUARTER_DEG : -QUARTER_DEG;
            end else begin
                xr = ux * (64'sd1 <<< FRAC_SHIFT);
                yr = sy * (64'sd1 <<< FRAC_SHIFT);
                zr = 0;
                for (int i = 0; i < ROTATIONS && i < 32; i++) begin
                    xs = xr >>> i;
                    ys = yr >>> i;
                    if (yr >= 0) begin
                        xr = xr + ys;
                        yr = yr - xs;
                        zr = zr + ATAN_STEP[i];
                    end else begin
                        xr = xr - ys;
                        yr = yr + xs;
                        zr = zr - ATAN_STEP[i];
                    end
                end
                a = (zr + 256) >>> ANGLE_ROUND_SHIFT;
                if (a > QUARTER_DEG)
                    a = QUARTER_DEG;
                if (a < -QUARTER_DEG)
                    a = -QUARTER_DEG;
                // left half-plane mirrors across the 90 degree line
                ang = (sx > 0) ? a : HALF_DEG - a;
            end
            res.mag = root[MAG_W-1:0];
            res.ang = ang[ANGLE_W-1:0];
            return res;
        endfunction

        function void note_input(logic signed [CW-1:0] fx, logic signed [CW-1:0] fy,
                                 logic signed [CW-1:0] gx, logic signed [CW-1:0] gy);
            pending.push_back(polar_of_sum(fx, fy, gx, gy));
        endfunction

        function void log_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        function void check_result(logic [MAG_W-1:0] mag, logic signed [ANGLE_W-1:0] ang,
                                   logic zero);
            t_polar want;
            checked++;
            if (pending.size() == 0) begin
                log_mismatch($sformatf("unexpected result mag=%0d ang=%0d zero=%0b",
                                       mag, ang, zero));
            end else begin
                want = pending.pop_front();
                if (mag !== want.mag || ang !== want.ang || zero !== want.zero)
                    log_mismatch($sformatf(
                        "result %0d: mag exp %0d got %0d, ang exp %0d got %0d, zero %0b/%0b",
                        checked, want.mag, mag, want.ang, ang, want.zero, zero));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    vsp_in_if #(.W(CW)) vec_if ();
    vsp_out_if          pol_if ();

    vector_sum_to_polar #(
        .COMPONENT_WIDTH   (CW),
        .CORDIC_ITERATIONS (ROTATIONS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vec   (vec_if),
        .o_pol   (pol_if)
    );

    polar_scoreboard sb = new();
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int pairs_sent     = 0;
    int cycles         = 0;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb NOT OK");
            $finish;
        end
    end

    // result side: check accepted items, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && pol_if.valid && pol_if.ready)
            sb.check_result(pol_if.sum_magnitude, pol_if.sum_angle, pol_if.zero_vector);
        pol_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_vec(input logic signed [CW-1:0] fx, input logic signed [CW-1:0] fy,
                            input logic signed [CW-1:0] gx, input logic signed [CW-1:0] gy);
        while ($urandom_range(99) < src_idle_pct) begin
            vec_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        vec_if.valid    <= 1'b1;
        vec_if.first_x  <= fx;
        vec_if.first_y  <= fy;
        vec_if.second_x <= gx;
        vec_if.second_y <= gy;
        do @(posedge i_clk); while (vec_if.ready !== 1'b1);
        sb.note_input(fx, fy, gx, gy);
        pairs_sent++;
    endtask

    function automatic logic signed [CW-1:0] corner_value();
        case ($urandom_range(4))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    initial begin
        logic signed [CW-1:0] ax, ay, bx, by;
        i_rst_n         <= 1'b0;
        vec_if.valid    <= 1'b0;
        vec_if.first_x  <= '0;
        vec_if.first_y  <= '0;
        vec_if.second_x <= '0;
        vec_if.second_y <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero sum, vertical sums, axes, corners, near-vertical on both sides
        send_vec(0, 0, 0, 0);
        send_vec(100, -50, -100, 50);
        send_vec(0, 5, 0, 7);
        send_vec(3, -9, -3, -1);
        send_vec(32767, 32767, 32767, 32767);
        send_vec(-32768, -32768, -32768, -32768);
        send_vec(32767, -32768, 32767, -32768);
        send_vec(-32768, 32767, -32768, 32767);
        send_vec(10, 0, 5, 0);
        send_vec(-10, 0, -5, 0);
        send_vec(1, 0, 0, 0);
        send_vec(-1, 0, 0, 0);
        send_vec(0, 1, 0, 0);
        send_vec(0, -1, 0, 0);
        send_vec(1, 32767, 0, 32767);
        send_vec(-1, 32767, 0, 32767);
        send_vec(1, -32768, 0, -32768);
        send_vec(-1, -32768, 0, -32768);
        send_vec(32767, 1, 32767, 0);
        send_vec(-32768, -1, -32768, 0);
        send_vec(3, 4, 0, 0);
        send_vec(-32768, 0, 32767, 0);
        send_vec(32767, -32768, -32768, 32767);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 87; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 87; end
                default: begin src_idle_pct = 37; sink_stall_pct = 37; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                ax = CW'($urandom());
                ay = CW'($urandom());
                bx = CW'($urandom());
                by = CW'($urandom());
                case ($urandom_range(99)) inside
                    [0:39]:  ;
                    [40:54]: begin
                        ax = CW'(int'($urandom_range(16)) - 8);
                        ay = CW'(int'($urandom_range(16)) - 8);
                        bx = CW'(int'($urandom_range(16)) - 8);
                        by = CW'(int'($urandom_range(16)) - 8);
                    end
                    [55:64]: begin
                        bx = -ax;
                        by = -ay;
                    end
                    [65:74]: bx = -ax;
                    [75:84]: by = -ay;
                    default: begin
                        ax = corner_value();
                        ay = corner_value();
                        bx = corner_value();
                        by = corner_value();
                    end
                endcase
                send_vec(ax, ay, bx, by);
            end
        end
        vec_if.valid <= 1'b0;

        // drain with the receiver always ready
        sink_stall_pct = 0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d vector pairs sent and %0d results checked, %0d mismatches", pairs_sent,
                 sb.checked, sb.mismatches);
        $display("covered zero and vertical sums, corners, and four idle/stall phases");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
